### hw/rtl/triangle_unit_normal_macros.svh
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Shared concurrent assertion forms for the checker of the normal unit.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// Checked on every rising edge outside reset.
`define TUN_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("triangle_unit_normal: assertion failed");

// Checked on every rising edge, reset included.
`define TUN_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("triangle_unit_normal: assertion failed");

`endif

### hw/rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, item types and stage payloads shared by the normal unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  // Input coordinates and derived widths of the exact cross product.
  localparam int COORD_BITS   = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int MAG_W        = PROD_W;
  localparam int SH_W         = $clog2(MAG_W);
  localparam int FRONT_STAGES = 7;

  // The largest normalised magnitude, unless all are zero, sits in [2^(NORM_W-1), 2^NORM_W).
  localparam int NORM_W   = 30;
  localparam int NORM_TOP = NORM_W - 1;
  localparam int SQ_W     = 2 * NORM_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int SQ_STEPS = SUM_W / 2;
  localparam int ROOT_W   = NORM_W + 1;

  // Output format and the quotient of the final division.
  localparam int NFRAC = 14;
  localparam int QUO_W = NFRAC + 1;
  localparam int DIV_W = ROOT_W + 1;
  localparam int REM_W = NORM_W + QUO_W + 1;
  localparam int OUT_W = 16;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] first_end_z;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
    logic signed [COORD_BITS-1:0] second_end_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } tun_out_t;

  // Payload of the square root chain.
  typedef struct packed {
    logic [SUM_W-1:0]            rem;
    logic [SUM_W-1:0]            root;
    logic [2:0][NORM_W-1:0]      mag;
    logic [2:0]                  neg;
    logic                        degen;
  } tun_sq_t;

  // Payload of the division chain, three components side by side.
  typedef struct packed {
    logic [2:0][REM_W-1:0]       rem;
    logic [2:0][QUO_W-1:0]       quo;
    logic [DIV_W-1:0]            dvs;
    logic [2:0]                  neg;
    logic                        degen;
  } tun_dv_t;

endpackage

`default_nettype wire

### hw/rtl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Stages: 7 front-end stages, 31 root cells, 1 set-up stage, 15 divide
// cells and 1 output register, each holding one item.
// Throughput: one item per cycle while the output is not stalled; every stage
// is its own register, so a bubble anywhere is squeezed out.
// Reset clears only the valid bits; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  tun_in_t  in_item_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output tun_out_t out_item_o,
  input  logic     out_stall_i
);

  // The front end forms the exact cross product, shifts all three magnitudes
  // by one common amount so that the largest sits just below 2^30 and sums
  // their squares. Then come the root cells, set-up, divide cells and output.
  logic    fr_rdy;

  logic    sq_v [SQ_STEPS+1];
  tun_sq_t sq_d [SQ_STEPS+1];
  logic    sq_r [SQ_STEPS+1];

  tun_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .rdy_o   (fr_rdy),
    .valid_o (sq_v[0]),
    .data_o  (sq_d[0]),
    .rdy_i   (sq_r[0])
  );

  assign in_stall_o = !fr_rdy;

  // The square root runs as a chain of cells, each settling one bit pair,
  // highest first, from the radicand's top bit pair down. A cell above the
  // value's leading bit pair simply passes a zero root along.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    tun_sqrt_cell #(
      .BIT_IDX (2 * (SQ_STEPS - 1 - k))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[k]),
      .data_i  (sq_d[k]),
      .rdy_o   (sq_r[k]),
      .valid_o (sq_v[k+1]),
      .data_o  (sq_d[k+1]),
      .rdy_i   (sq_r[k+1])
    );
  end

  // Set-up for the division. Rounding to nearest, halves away from zero, is
  // floor((a * 2^(F+1) + L) / (2 * L)), so the dividend carries L and the
  // divisor is twice the root. As every magnitude is at most the root, the
  // quotient fits in F+1 bits and the chain needs F+1 cells.
  logic    pre_v_q;
  logic    pre_ld;
  tun_dv_t pre_d;
  tun_dv_t pre_q;

  logic    dv_v [QUO_W+1];
  tun_dv_t dv_d [QUO_W+1];
  logic    dv_r [QUO_W+1];

  assign pre_ld = !pre_v_q || dv_r[0];
  assign sq_r[SQ_STEPS] = pre_ld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pre_d.rem[i] = (REM_W'(sq_d[SQ_STEPS].mag[i]) << QUO_W)
                   + REM_W'(sq_d[SQ_STEPS].root[ROOT_W-1:0]);
    end
    pre_d.quo   = '0;
    pre_d.dvs   = {sq_d[SQ_STEPS].root[ROOT_W-1:0], 1'b0};
    pre_d.neg   = sq_d[SQ_STEPS].neg;
    pre_d.degen = sq_d[SQ_STEPS].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else if (pre_ld) begin
      pre_v_q <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_ld) pre_q <= pre_d;
  end

  assign dv_v[0] = pre_v_q;
  assign dv_d[0] = pre_q;

  // Restoring division, one quotient bit per cell for all three components.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    tun_div_cell #(
      .SHIFT (QUO_W - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[k]),
      .data_i  (dv_d[k]),
      .rdy_o   (dv_r[k]),
      .valid_o (dv_v[k+1]),
      .data_o  (dv_d[k+1]),
      .rdy_i   (dv_r[k+1])
    );
  end

  // Output register. It loads whenever it is empty or its item is being
  // taken; while a result waits, the stages before it fill up and then stall.
  localparam logic [QUO_W-1:0] UnitQuo = QUO_W'(1) << NFRAC;

  logic             out_ld;
  logic [QUO_W-1:0] clamped;
  logic [OUT_W-1:0] cmag;
  logic [OUT_W-1:0] comp [3];
  tun_out_t         res_d;
  tun_out_t         res_q;
  logic             out_v_q;

  assign out_ld = !out_v_q || !out_stall_i;
  assign dv_r[QUO_W] = out_ld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      clamped = (dv_d[QUO_W].quo[i] > UnitQuo) ? UnitQuo : dv_d[QUO_W].quo[i];
      cmag    = OUT_W'(clamped);
      comp[i] = dv_d[QUO_W].neg[i] ? -cmag : cmag;
      // A zero cross product gives a zero normal and raises the flag.
      if (dv_d[QUO_W].degen) comp[i] = '0;
    end
    res_d.normal_x   = comp[0];
    res_d.normal_y   = comp[1];
    res_d.normal_z   = comp[2];
    res_d.degenerate = dv_d[QUO_W].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ld) begin
      out_v_q <= dv_v[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) res_q <= res_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = res_q;

endmodule

`default_nettype wire

### hw/rtl/tun_front.sv
// ----------------------------------------------------------------------------
// Triangle unit normal front end
// Edge vectors, cross product, normalising shift and sum of squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_front import tun_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  tun_in_t item_i,
  output logic    rdy_o,
  output logic    valid_o,
  output tun_sq_t data_o,
  input  logic    rdy_i
);

  logic [FRONT_STAGES-1:0] v_q;
  logic [FRONT_STAGES:0]   ld;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    ld[FRONT_STAGES] = rdy_i;
    for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= valid_i;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: edge vectors.
  logic signed [DIFF_W-1:0] dif_d [6];
  logic signed [DIFF_W-1:0] dif_q [6];

  always_comb begin
    dif_d[0] = DIFF_W'(item_i.first_end_x)  - DIFF_W'(item_i.vertex_x);
    dif_d[1] = DIFF_W'(item_i.first_end_y)  - DIFF_W'(item_i.vertex_y);
    dif_d[2] = DIFF_W'(item_i.first_end_z)  - DIFF_W'(item_i.vertex_z);
    dif_d[3] = DIFF_W'(item_i.second_end_x) - DIFF_W'(item_i.vertex_x);
    dif_d[4] = DIFF_W'(item_i.second_end_y) - DIFF_W'(item_i.vertex_y);
    dif_d[5] = DIFF_W'(item_i.second_end_z) - DIFF_W'(item_i.vertex_z);
  end

  // Stage 2: the six partial products. Index order is v x, y, z, w x, y, z.
  logic signed [PROD_W-1:0] prd_d [6];
  logic signed [PROD_W-1:0] prd_q [6];

  always_comb begin
    prd_d[0] = dif_q[1] * dif_q[5];
    prd_d[1] = dif_q[4] * dif_q[2];
    prd_d[2] = dif_q[3] * dif_q[2];
    prd_d[3] = dif_q[0] * dif_q[5];
    prd_d[4] = dif_q[0] * dif_q[4];
    prd_d[5] = dif_q[3] * dif_q[1];
  end

  // Stage 3: cross product split into sign and magnitude.
  logic signed [CROSS_W-1:0] crs    [3];
  logic [2:0][MAG_W-1:0]     mag3_d;
  logic [2:0][MAG_W-1:0]     mag3_q;
  logic [2:0]                neg3_d;
  logic [2:0]                neg3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crs[i]    = CROSS_W'(prd_q[2*i]) - CROSS_W'(prd_q[2*i+1]);
      neg3_d[i] = crs[i][CROSS_W-1];
      mag3_d[i] = neg3_d[i] ? MAG_W'(-crs[i]) : MAG_W'(crs[i]);
    end
  end

  // Stage 4: the top set bit of the largest magnitude is that of their OR.
  logic [MAG_W-1:0]      orv;
  logic [SH_W-1:0]       pos_d;
  logic [SH_W-1:0]       pos_q;
  logic [2:0][MAG_W-1:0] mag4_q;
  logic [2:0]            neg4_q;
  logic                  dg4_q;

  always_comb begin
    orv   = mag3_q[0] | mag3_q[1] | mag3_q[2];
    pos_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) pos_d = SH_W'(i);
    end
  end

  // Stage 5: one common shift, right with truncation or left.
  logic [2:0][NORM_W-1:0] nm_d;
  logic [2:0][NORM_W-1:0] nm5_q;
  logic [2:0]             neg5_q;
  logic                   dg5_q;
  logic [MAG_W-1:0]       shv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_q >= SH_W'(NORM_TOP)) begin
        shv[i] = mag4_q[i] >> (pos_q - SH_W'(NORM_TOP));
      end else begin
        shv[i] = mag4_q[i] << (SH_W'(NORM_TOP) - pos_q);
      end
      nm_d[i] = shv[i][NORM_W-1:0];
    end
  end

  // Stage 6: squares.
  logic [SQ_W-1:0]        sq_d [3];
  logic [SQ_W-1:0]        sq_q [3];
  logic [2:0][NORM_W-1:0] nm6_q;
  logic [2:0]             neg6_q;
  logic                   dg6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = nm5_q[i] * nm5_q[i];
    end
  end

  // Stage 7: sum of squares, the radicand of the root chain.
  tun_sq_t out_d;
  tun_sq_t out_q;

  always_comb begin
    out_d.rem   = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    out_d.root  = '0;
    out_d.mag   = nm6_q;
    out_d.neg   = neg6_q;
    out_d.degen = dg6_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) dif_q <= dif_d;
    if (ld[1]) prd_q <= prd_d;
    if (ld[2]) begin
      mag3_q <= mag3_d;
      neg3_q <= neg3_d;
    end
    if (ld[3]) begin
      pos_q  <= pos_d;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      dg4_q  <= (orv == '0);
    end
    if (ld[4]) begin
      nm5_q  <= nm_d;
      neg5_q <= neg4_q;
      dg5_q  <= dg4_q;
    end
    if (ld[5]) begin
      sq_q   <= sq_d;
      nm6_q  <= nm5_q;
      neg6_q <= neg5_q;
      dg6_q  <= dg5_q;
    end
    if (ld[6]) out_q <= out_d;
  end

  assign rdy_o   = ld[0];
  assign valid_o = v_q[FRONT_STAGES-1];
  assign data_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/tun_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Triangle unit normal root cell
// One bit pair of the integer square root, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_sqrt_cell import tun_pkg::*; #(
  parameter int BIT_IDX = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  tun_sq_t data_i,
  output logic    rdy_o,
  output logic    valid_o,
  output tun_sq_t data_o,
  input  logic    rdy_i
);

  localparam logic [SUM_W-1:0] StepBit = SUM_W'(1) << BIT_IDX;

  logic             v_q;
  logic             ld;
  logic [SUM_W-1:0] trial;
  tun_sq_t          d;
  tun_sq_t          q_q;

  assign ld = !v_q || rdy_i;

  always_comb begin
    trial = data_i.root + StepBit;
    d     = data_i;
    if (data_i.rem >= trial) begin
      d.rem  = data_i.rem - trial;
      d.root = (data_i.root >> 1) + StepBit;
    end else begin
      d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) q_q <= d;
  end

  assign rdy_o   = ld;
  assign valid_o = v_q;
  assign data_o  = q_q;

endmodule

`default_nettype wire

### hw/rtl/tun_div_cell.sv
// ----------------------------------------------------------------------------
// Triangle unit normal divide cell
// One quotient bit of the three component divisions, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_div_cell import tun_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  tun_dv_t data_i,
  output logic    rdy_o,
  output logic    valid_o,
  output tun_dv_t data_o,
  input  logic    rdy_i
);

  logic             v_q;
  logic             ld;
  logic [REM_W-1:0] sub;
  tun_dv_t          d;
  tun_dv_t          q_q;

  assign ld = !v_q || rdy_i;

  always_comb begin
    sub = REM_W'(data_i.dvs) << SHIFT;
    d   = data_i;
    for (int i = 0; i < 3; i++) begin
      if (data_i.rem[i] >= sub) begin
        d.rem[i] = data_i.rem[i] - sub;
        d.quo[i] = {data_i.quo[i][QUO_W-2:0], 1'b1};
      end else begin
        d.quo[i] = {data_i.quo[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) q_q <= d;
  end

  assign rdy_o   = ld;
  assign valid_o = v_q;
  assign data_o  = q_q;

endmodule

`default_nettype wire

### hw/rtl/tun_checker.sv
// ----------------------------------------------------------------------------
// Triangle unit normal checker
// Port-level assertions on the normal unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_unit_normal_macros.svh"

module tun_checker import tun_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input tun_in_t  in_item_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input tun_out_t out_item_o,
  input logic     out_stall_i
);

  localparam int UnitOne = 1 << NFRAC;

  logic in_seen;

  // An item taken at the input is evidence the ports are alive.
  assign in_seen = in_valid_i && !in_stall_o && (in_item_i != '0 || in_item_i == '0);

  // A stalled result holds until it is taken.
  `TUN_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

  // A degenerate triangle gives a zero normal.
  `TUN_ASSERT(a_degen_zero, out_valid_o && out_item_o.degenerate |-> out_item_o.normal_x == 0 && out_item_o.normal_y == 0 && out_item_o.normal_z == 0)

  // Every component lies within plus and minus one.
  `TUN_ASSERT(a_unit_range, out_valid_o |-> out_item_o.normal_x <= UnitOne && out_item_o.normal_x >= -UnitOne && out_item_o.normal_y <= UnitOne && out_item_o.normal_y >= -UnitOne && out_item_o.normal_z <= UnitOne && out_item_o.normal_z >= -UnitOne)

  // Nothing is shown during reset, and when an input is taken as reset ends,
  // no result appears in the cycle after it.
  `TUN_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o)
  `TUN_ASSERT(a_no_shortcut, $past(!rst_ni) && rst_ni && in_seen |=> !out_valid_o)

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_item_i   (in_item_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
